// ===== rtl/cts_pkg.sv =====
package cts_pkg;

  // Operation codes of the input item
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_DELETE   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_FULL       = 3'd1,
    STS_BAD_PERIOD = 3'd2,
    STS_BAD_DELAY  = 3'd3,
    STS_BAD_INDEX  = 3'd4,
    STS_RUN        = 3'd5,
    STS_NONE       = 3'd6
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_PROC = 2'd2,
    S_END  = 2'd3
  } state_t;

  // Most run results one dispatch may hand out
  localparam int RESULT_CAP = 16;
  localparam int RUN_CNT_W  = $clog2(RESULT_CAP + 1);

  // One table entry as stored in the task memory
  typedef struct packed {
    logic [7:0]  handle;
    logic [30:0] period;
    logic [30:0] delay;
    logic [7:0]  pending;
    logic        one_shot;
  } entry_t;

  // Controls of the shared entry update unit
  typedef struct packed {
    logic tick;
    logic take;
  } unit_ctl_t;

endpackage

// ===== rtl/cooperative_task_scheduler_table.sv =====
// Table of up to MAX_TASKS timed tasks, kept compacted in slots 0 to task_count-1 of a
// one-read, one-write memory. Add and any rejected request go straight to the final result.
// Tick, dispatch (both on a non-empty table) and a valid delete make one pass over the table
// through a single entry update unit, one entry per cycle while the result channel does not
// stall, with compaction done during the pass. in_ready is high only between items.
// Dispatch results come out in slot order; the final result of each item carries out_last.
module cooperative_task_scheduler_table #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_task_handle,
  input  logic [31:0] in_start_delay,
  input  logic [31:0] in_repeat_period,
  input  logic [5:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_slot_out,
  output logic [7:0]  out_run_handle,
  output logic        out_last
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CMP_W = 7;

  cts_pkg::state_t  state_r, state_nxt;
  cts_pkg::op_t     op_r;
  cts_pkg::op_t     in_op;
  cts_pkg::status_t resp_status_r;
  logic [5:0]       resp_slot_r;
  logic [5:0]       sidx_r;
  logic             walk_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] r_r;
  logic [CNT_W-1:0] w_r;
  logic [CNT_W-1:0] r_inc;
  logic [cts_pkg::RUN_CNT_W-1:0] n_r;

  logic             hold_v_r;
  logic [5:0]       hold_slot_r;
  logic [7:0]       hold_handle_r;

  logic             out_valid_r;
  cts_pkg::status_t out_status_r;
  logic [5:0]       out_slot_r;
  logic [7:0]       out_handle_r;
  logic             out_last_r;

  cts_pkg::entry_t  ent_mem [MAX_TASKS];
  cts_pkg::entry_t  rd_r;
  cts_pkg::entry_t  upd_ent;
  cts_pkg::entry_t  new_ent;
  cts_pkg::entry_t  wdata;
  cts_pkg::unit_ctl_t ctl;

  logic             accept;
  logic             out_free;
  logic             table_full;
  logic             add_ok;
  logic             del_bad;
  logic             emit;
  logic             drop;
  logic             stall;
  logic             step;
  logic             last_entry;
  logic             push_hold;
  logic             push_end;
  logic             we;
  logic             re;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;

  // Decode the incoming item
  assign in_op      = cts_pkg::op_t'(in_opcode);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign table_full = (count_r >= CNT_W'(MAX_TASKS));
  assign add_ok     = !table_full && !in_repeat_period[31] && !in_start_delay[31];
  assign del_bad    = (CMP_W'(in_slot_index) >= CMP_W'(count_r));

  // Walk decisions for the entry currently in rd_r
  assign r_inc      = r_r + CNT_W'(1);
  assign last_entry = (r_inc == count_r);
  assign emit       = (op_r == cts_pkg::OP_DISPATCH) && (rd_r.pending != 8'd0)
                      && (n_r < cts_pkg::RUN_CNT_W'(cts_pkg::RESULT_CAP));
  assign drop       = ((op_r == cts_pkg::OP_DELETE) && (CMP_W'(r_r) == CMP_W'(sidx_r)))
                      || (emit && rd_r.one_shot);
  assign stall      = emit && hold_v_r && !out_free;
  assign step       = (state_r == cts_pkg::S_PROC) && !stall;
  assign push_hold  = step && emit && hold_v_r;
  assign push_end   = (state_r == cts_pkg::S_END) && out_free;

  assign ctl.tick = (op_r == cts_pkg::OP_TICK);
  assign ctl.take = emit;

  cts_entry_unit u_unit (
    .ent_i (rd_r),
    .ctl_i (ctl),
    .ent_o (upd_ent)
  );

  // Build the entry that add appends
  always_comb begin
    new_ent.handle   = in_task_handle;
    new_ent.period   = in_repeat_period[30:0];
    new_ent.delay    = in_start_delay[30:0];
    new_ent.pending  = 8'd0;
    new_ent.one_shot = (in_repeat_period == 32'd0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cts_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            cts_pkg::OP_ADD: begin
              state_nxt = cts_pkg::S_END;
            end
            cts_pkg::OP_DELETE: begin
              state_nxt = del_bad ? cts_pkg::S_END : cts_pkg::S_READ;
            end
            default: begin
              state_nxt = (count_r == '0) ? cts_pkg::S_END : cts_pkg::S_READ;
            end
          endcase
        end
      end
      cts_pkg::S_READ: begin
        state_nxt = cts_pkg::S_PROC;
      end
      cts_pkg::S_PROC: begin
        if (step && last_entry) begin
          state_nxt = cts_pkg::S_END;
        end
      end
      cts_pkg::S_END: begin
        if (out_free) begin
          state_nxt = cts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cts_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake and memory ports
  always_comb begin
    in_ready = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = w_r[IDX_W-1:0];
    raddr    = r_inc[IDX_W-1:0];
    wdata    = upd_ent;
    case (state_r)
      cts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        waddr    = count_r[IDX_W-1:0];
        wdata    = new_ent;
        we       = accept && (in_op == cts_pkg::OP_ADD) && add_ok;
      end
      cts_pkg::S_READ: begin
        re    = 1'b1;
        raddr = r_r[IDX_W-1:0];
      end
      cts_pkg::S_PROC: begin
        we = step && !drop;
        re = step && !last_entry;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Task memory
  always_ff @(posedge clk) begin
    if (we) begin
      ent_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= ent_mem[raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cts_pkg::S_IDLE;
      count_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (we && (state_r == cts_pkg::S_IDLE)) begin
        count_r <= count_r + CNT_W'(1);
      end else if (push_end && walk_r) begin
        count_r <= w_r;
      end
      if (accept || push_end) begin
        hold_v_r <= 1'b0;
      end else if (step && emit) begin
        hold_v_r <= 1'b1;
      end
      if (push_hold || push_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the item and advance the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      sidx_r <= in_slot_index;
      r_r    <= '0;
      w_r    <= '0;
      n_r    <= '0;
      case (in_op)
        cts_pkg::OP_ADD: begin
          walk_r      <= 1'b0;
          resp_slot_r <= add_ok ? 6'(count_r) : 6'd0;
          if (table_full) begin
            resp_status_r <= cts_pkg::STS_FULL;
          end else if (in_repeat_period[31]) begin
            resp_status_r <= cts_pkg::STS_BAD_PERIOD;
          end else if (in_start_delay[31]) begin
            resp_status_r <= cts_pkg::STS_BAD_DELAY;
          end else begin
            resp_status_r <= cts_pkg::STS_OK;
          end
        end
        cts_pkg::OP_DELETE: begin
          walk_r        <= !del_bad;
          resp_slot_r   <= in_slot_index;
          resp_status_r <= del_bad ? cts_pkg::STS_BAD_INDEX : cts_pkg::STS_OK;
        end
        default: begin
          walk_r        <= 1'b1;
          resp_slot_r   <= 6'd0;
          resp_status_r <= cts_pkg::STS_OK;
        end
      endcase
    end else if (step) begin
      r_r <= r_inc;
      if (!drop) begin
        w_r <= w_r + CNT_W'(1);
      end
      if (emit) begin
        n_r           <= n_r + cts_pkg::RUN_CNT_W'(1);
        hold_slot_r   <= 6'(w_r);
        hold_handle_r <= rd_r.handle;
      end
    end
  end

  // Result register: hold back each run until the next one shows it is not final
  always_ff @(posedge clk) begin
    if (push_hold) begin
      out_status_r <= cts_pkg::STS_RUN;
      out_slot_r   <= hold_slot_r;
      out_handle_r <= hold_handle_r;
      out_last_r   <= 1'b0;
    end else if (push_end) begin
      out_last_r <= 1'b1;
      if (op_r == cts_pkg::OP_DISPATCH) begin
        out_status_r <= hold_v_r ? cts_pkg::STS_RUN : cts_pkg::STS_NONE;
        out_slot_r   <= hold_v_r ? hold_slot_r : 6'd0;
        out_handle_r <= hold_v_r ? hold_handle_r : 8'd0;
      end else begin
        out_status_r <= resp_status_r;
        out_slot_r   <= resp_slot_r;
        out_handle_r <= 8'd0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_run_handle = out_handle_r;
  assign out_last       = out_last_r;

  // Table never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("task count above capacity");

  // Compaction write pointer never passes the read pointer
  a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cts_pkg::S_PROC) |-> (w_r <= r_r))
    else $error("write pointer ahead of read pointer");

  // Only a dispatch holds back a run result
  a_hold_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && (state_r != cts_pkg::S_IDLE)) |-> (op_r == cts_pkg::OP_DISPATCH))
    else $error("held run outside dispatch");

  // Run results per dispatch stay within the cap
  a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cts_pkg::S_PROC) |-> (n_r <= cts_pkg::RUN_CNT_W'(cts_pkg::RESULT_CAP)))
    else $error("dispatch result cap exceeded");

  // Final result returns to idle with no run left behind
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    push_end |=> ((state_r == cts_pkg::S_IDLE) && !hold_v_r && out_valid_r && out_last_r))
    else $error("item did not close cleanly");

endmodule

// ===== rtl/cts_entry_unit.sv =====
module cts_entry_unit (
  input  cts_pkg::entry_t    ent_i,
  input  cts_pkg::unit_ctl_t ctl_i,
  output cts_pkg::entry_t    ent_o
);

  logic [30:0] delay_dec;
  logic        due;

  // Count down and detect expiry
  assign delay_dec = ent_i.delay - 31'd1;
  assign due       = (ent_i.delay == 31'd0) || (delay_dec == 31'd0);

  // Apply tick or take one pending run
  always_comb begin
    ent_o = ent_i;
    if (ctl_i.tick) begin
      if (ent_i.delay != 31'd0) begin
        ent_o.delay = delay_dec;
      end
      if (due) begin
        if (ent_i.pending != 8'hff) begin
          ent_o.pending = ent_i.pending + 8'd1;
        end
        if (ent_i.period != 31'd0) begin
          ent_o.delay = ent_i.period;
        end
      end
    end else if (ctl_i.take) begin
      ent_o.pending = ent_i.pending - 8'd1;
    end
  end

endmodule
